// File: rtl/core/tes_pkg.sv
package tes_pkg;

  // request codes carried in s_axis_tuser
  localparam logic [2:0] REQ_CLEAR  = 3'd0;
  localparam logic [2:0] REQ_ADD    = 3'd1;
  localparam logic [2:0] REQ_START  = 3'd2;
  localparam logic [2:0] REQ_STOP   = 3'd3;
  localparam logic [2:0] REQ_ADV    = 3'd4;
  localparam logic [2:0] REQ_POLL   = 3'd5;
  localparam logic [2:0] REQ_EXTEND = 3'd6;

  // configuration register indexes
  localparam logic [7:0] CFG_FADE_IN  = 8'd0;
  localparam logic [7:0] CFG_FADE_OUT = 8'd1;

  // Q1.16 unity
  localparam logic [16:0] FADE_ONE = 17'h10000;

  localparam int QUOT_BITS = 16;

  // poll token walking the mark cells
  typedef struct packed {
    logic        valid;
    logic        found;
    logic [15:0] event_code;
  } scan_t;

  typedef struct packed {
    logic        start;
    logic [31:0] part;
    logic [31:0] whole;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quot;
  } div_rsp_t;

endpackage

// File: rtl/core/tes_cell.sv
// one mark slot; the poll token is registered as it passes through
module tes_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  logic [31:0]       wr_time,
  input  logic [15:0]       wr_event,
  input  logic              rearm,
  input  logic              live,
  input  logic [31:0]       clock_time,
  input  tes_pkg::scan_t    tok_in,
  output tes_pkg::scan_t    tok_out
);

  logic [31:0] mark_time;
  logic [15:0] mark_event;
  logic        mark_done;
  logic        hit;

  assign hit = tok_in.valid && !tok_in.found && live && !mark_done &&
               (clock_time >= mark_time);

  always_ff @(posedge clk) begin
    if (wr) begin
      mark_time  <= wr_time;
      mark_event <= wr_event;
      mark_done  <= 1'b0;
    end else if (rearm) begin
      mark_done <= 1'b0;
    end else if (hit) begin
      mark_done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    if (hit) begin
      tok_out.found      <= 1'b1;
      tok_out.event_code <= mark_event;
    end else begin
      tok_out.found      <= tok_in.found;
      tok_out.event_code <= tok_in.event_code;
    end
  end

endmodule

// File: rtl/core/tes_div.sv
// restoring divider, one quotient bit per cycle; part < whole
module tes_div (
  input  logic                clk,
  input  logic                rst,
  input  tes_pkg::div_req_t   req,
  output tes_pkg::div_rsp_t   rsp
);

  localparam int CNT_W = $clog2(tes_pkg::QUOT_BITS);

  logic [31:0]      rem;
  logic [31:0]      whole;
  logic [15:0]      quot;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [32:0]      trial;
  logic             take;

  assign trial = {rem, 1'b0};
  assign take  = trial >= {1'b0, whole};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(tes_pkg::QUOT_BITS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= req.part;
      whole <= req.whole;
      quot  <= '0;
      cnt   <= '0;
    end else if (busy) begin
      rem  <= take ? 32'(trial - {1'b0, whole}) : trial[31:0];
      quot <= {quot[14:0], take};
      cnt  <= cnt + CNT_W'(1);
    end
  end

  // done sits above quot in div_rsp_t
  assign rsp = {done, quot};

endmodule

// File: rtl/core/timeline_event_sequencer_top.sv
// Timeline event sequencer. One request beat at a time is taken on the
// slave stream (tuser = request code, tdata = time and event code) and
// produces exactly one result beat. Marks live in a row of MARK_SLOTS
// cells; a poll sends a token down the row, one cell per cycle, and the
// first armed, due mark it meets fires. The fade fraction comes from a
// serial divider producing one quotient bit per cycle. An accepted
// request passes through EXEC, SCAN (polls only, for the token walk
// through the cell row), FADE_A, FADE_B, DIV (only when a fade ramp
// is active) and HOLD, where the result is registered; the sequencer
// then returns to IDLE to take the next request. A stalled receiver
// adds its stall once the output register is still full when the next
// result is ready. s_axis_tready is high whenever the sequencer is
// idle, even while the previous result still waits in the output
// register. No reset sweep is needed: slots beyond the mark count are
// never consulted.
module timeline_event_sequencer_top #(
  parameter int MARK_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [31:0] time_value, [47:32] event_code
  input  logic [2:0]  s_axis_tuser,   // [2:0] req_type
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [0] status, [1] event_found,
                                      // [17:2] fired_event, [18] is_playing,
                                      // [35:19] fade_level, [39:36] zero
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int CW = $clog2(MARK_SLOTS + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_FADE_A = 3'd3;
  localparam logic [2:0] ST_FADE_B = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_HOLD   = 3'd6;

  logic [2:0]  state;

  // config
  logic [31:0] fade_in_time;
  logic [31:0] fade_out_time;

  // timeline state
  logic [31:0]   clock_time;
  logic [31:0]   timeline_length;
  logic          playing_flag;
  logic [CW-1:0] mark_count;

  // latched request
  logic [2:0]  req;
  logic [31:0] tv;
  logic [15:0] ev;

  // per-request results
  logic        status;
  logic        found;
  logic [15:0] fired;
  logic [16:0] fade;
  logic        adv_chk;

  // fade decision flags
  logic        in_win;
  logic        ge_len;
  logic [31:0] left;

  // cell row
  logic [MARK_SLOTS-1:0] wr_vec;
  logic                  rearm;
  logic                  tok_start;
  tes_pkg::scan_t        tok [MARK_SLOTS+1];

  tes_pkg::div_req_t div_req;
  tes_pkg::div_rsp_t div_rsp;

  logic [32:0] sum;

  assign sum       = {1'b0, clock_time} + {1'b0, tv};
  assign rearm     = (state == ST_EXEC) && (req == tes_pkg::REQ_START);
  assign tok_start = (state == ST_EXEC) && (req == tes_pkg::REQ_POLL);

  assign tok[0].valid      = tok_start;
  assign tok[0].found      = 1'b0;
  assign tok[0].event_code = 16'd0;

  for (genvar i = 0; i < MARK_SLOTS; i++) begin : g_cell
    assign wr_vec[i] = (state == ST_EXEC) && (req == tes_pkg::REQ_ADD) &&
                       (mark_count == CW'(i));
    tes_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .wr         (wr_vec[i]),
      .wr_time    (tv),
      .wr_event   (ev),
      .rearm      (rearm),
      .live       (mark_count > CW'(i)),
      .clock_time (clock_time),
      .tok_in     (tok[i]),
      .tok_out    (tok[i+1])
    );
  end

  tes_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_in_time  <= '0;
      fade_out_time <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == tes_pkg::CFG_FADE_IN) begin
        fade_in_time <= cfg_data;
      end else if (cfg_index == tes_pkg::CFG_FADE_OUT) begin
        fade_out_time <= cfg_data;
      end
    end
  end

  // divider launch is decided in FADE_B
  always_comb begin
    div_req.start = 1'b0;
    div_req.part  = clock_time;
    div_req.whole = fade_in_time;
    if (state == ST_FADE_B) begin
      if (in_win) begin
        div_req.start = 1'b1;
      end else if (fade_out_time != '0 && !ge_len && left < fade_out_time) begin
        div_req.start = 1'b1;
        div_req.part  = left;
        div_req.whole = fade_out_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      clock_time      <= '0;
      timeline_length <= '0;
      playing_flag    <= 1'b0;
      mark_count      <= '0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      // a new result may replace the one leaving in this cycle
      if (state == ST_HOLD && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= (req == tes_pkg::REQ_POLL) ? ST_SCAN : ST_FADE_A;
          unique case (req)
            tes_pkg::REQ_CLEAR: begin
              clock_time      <= '0;
              timeline_length <= '0;
              playing_flag    <= 1'b0;
              mark_count      <= '0;
            end
            tes_pkg::REQ_ADD: begin
              if (mark_count < CW'(MARK_SLOTS)) begin
                mark_count <= mark_count + CW'(1);
                if (tv > timeline_length) begin
                  timeline_length <= tv;
                end
              end
            end
            tes_pkg::REQ_START: begin
              clock_time   <= '0;
              playing_flag <= 1'b1;
            end
            tes_pkg::REQ_STOP: begin
              playing_flag <= 1'b0;
            end
            tes_pkg::REQ_ADV: begin
              if (playing_flag) begin
                clock_time <= sum[32] ? '1 : sum[31:0];
              end
            end
            tes_pkg::REQ_EXTEND: begin
              if (tv > timeline_length) begin
                timeline_length <= tv;
              end
            end
            default: begin
            end
          endcase
        end
        ST_SCAN: begin
          if (tok[MARK_SLOTS].valid) begin
            state <= ST_FADE_A;
          end
        end
        ST_FADE_A: begin
          // advance stops play once the clock reaches the end
          if (adv_chk && clock_time >= timeline_length) begin
            playing_flag <= 1'b0;
          end
          state <= ST_FADE_B;
        end
        ST_FADE_B: begin
          state <= div_req.start ? ST_DIV : ST_HOLD;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_axis_tvalid) begin
      req     <= s_axis_tuser;
      tv      <= s_axis_tdata[31:0];
      ev      <= s_axis_tdata[47:32];
      status  <= 1'b0;
      found   <= 1'b0;
      fired   <= 16'd0;
      adv_chk <= 1'b0;
    end
    if (state == ST_EXEC) begin
      status  <= (req == tes_pkg::REQ_ADD) && (mark_count >= CW'(MARK_SLOTS));
      adv_chk <= (req == tes_pkg::REQ_ADV) && playing_flag;
    end
    if (state == ST_SCAN && tok[MARK_SLOTS].valid) begin
      found <= tok[MARK_SLOTS].found;
      fired <= tok[MARK_SLOTS].found ? tok[MARK_SLOTS].event_code : 16'd0;
    end
    if (state == ST_FADE_A) begin
      in_win <= (fade_in_time != '0) && (clock_time < fade_in_time);
      ge_len <= clock_time >= timeline_length;
      left   <= timeline_length - clock_time;
    end
    if (state == ST_FADE_B) begin
      if (!in_win && fade_out_time != '0 && ge_len) begin
        fade <= tes_pkg::FADE_ONE;
      end else begin
        fade <= 17'd0;
      end
    end
    if (state == ST_DIV && div_rsp.done) begin
      fade <= tes_pkg::FADE_ONE - {1'b0, div_rsp.quot};
    end
    if (state == ST_HOLD && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {4'd0, fade, playing_flag, fired, found, status};
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    mark_count <= CW'(MARK_SLOTS))
    else $error("mark count beyond slot count");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ST_DIV)
    else $error("divider finished outside divide state");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> state == ST_EXEC)
    else $error("accepted request not executed");

  a_token_scan: assert property (@(posedge clk) disable iff (rst)
    tok[MARK_SLOTS].valid |-> state == ST_SCAN)
    else $error("poll token left cell row outside scan");
`endif

endmodule
